// ===== src/u8d_pkg.sv =====
// Shared types for the UTF-8 stream decoder: transfer payloads, the
// look-ahead window and the decoded head character. No dependencies.
`default_nettype none

package u8d_pkg;

    localparam int unsigned WindowBytes = 4;

    typedef logic [WindowBytes-1:0][7:0] t_window;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [20:0] code_point;
        logic [8:0]  error_mask;
        logic [2:0]  bytes_used;
        logic        last_char;
    } t_out_item;

    typedef struct packed {
        logic [20:0] code_point;
        logic [8:0]  error_mask;
        logic [2:0]  bytes_used;
    } t_head;

endpackage

`default_nettype wire

// ===== src/u8d_head_decode.sv =====
// Combinational decode of the character at the head of the window.
// Depends on u8d_pkg for the window and head types.
`default_nettype none

module u8d_head_decode
    import u8d_pkg::*;
(
    input  t_window i_window,
    output t_head   o_head
);

    localparam logic [31:0][2:0] LenTable = {
        3'd0, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
    };

    logic [7:0]  w_b0, w_b1, w_b2, w_b3;
    logic [2:0]  w_len;
    logic [6:0]  w_lead;
    logic [24:0] w_raw;
    logic [20:0] w_cp;
    logic        w_small;
    logic [8:0]  w_err_raw;
    logic [8:0]  w_err;

    assign w_b0  = i_window[0];
    assign w_b1  = i_window[1];
    assign w_b2  = i_window[2];
    assign w_b3  = i_window[3];
    assign w_len = LenTable[w_b0[7:3]];

    always_comb begin
        case (w_len)
            3'd1:    w_lead = w_b0[6:0];
            3'd2:    w_lead = {2'b00, w_b0[4:0]};
            3'd3:    w_lead = {3'b000, w_b0[3:0]};
            3'd4:    w_lead = {4'b0000, w_b0[2:0]};
            default: w_lead = 7'd0;
        endcase
    end

    assign w_raw = {w_lead, w_b1[5:0], w_b2[5:0], w_b3[5:0]};

    always_comb begin
        case (w_len)
            3'd1:    w_cp = 21'(w_raw >> 18);
            3'd2:    w_cp = 21'(w_raw >> 12);
            3'd3:    w_cp = 21'(w_raw >> 6);
            default: w_cp = w_raw[20:0];
        endcase
    end

    always_comb begin
        case (w_len)
            3'd1:    w_small = 1'b0;
            3'd2:    w_small = (w_cp < 21'd128);
            3'd3:    w_small = (w_cp < 21'd2048);
            3'd4:    w_small = (w_cp < 21'd65536);
            default: w_small = 1'b1;
        endcase
    end

    assign w_err_raw = {(w_cp > 21'h10FFFF), (w_cp[20:11] == 10'h1b), w_small,
                        w_b1[7:6], w_b2[7:6], w_b3[7:6]} ^ 9'h02a;

    always_comb begin
        case (w_len)
            3'd1:    w_err = w_err_raw >> 6;
            3'd2:    w_err = w_err_raw >> 4;
            3'd3:    w_err = w_err_raw >> 2;
            default: w_err = w_err_raw;
        endcase
    end

    assign o_head.code_point = w_cp;
    assign o_head.error_mask = w_err;
    assign o_head.bytes_used = (w_len == 3'd0) ? 3'd1 : w_len;

endmodule

`default_nettype wire

// ===== src/utf8_stream_decoder.sv =====
// UTF-8 stream decoder: one byte per transfer in, one character per transfer out.
// Output is registered, valid in the cycle after the byte that fills the window; an
// end_of_text byte is stored first and the flushed characters are decoded from it.
// Throughput, while the output is not stalled: one byte per cycle; after an end_of_text
// byte the input holds while the flush emits one character per cycle (up to four).
// Reset (synchronous, active low) empties the window and drops any pending result.
// Depends on u8d_pkg and u8d_head_decode.
`default_nettype none

module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out_item  o_out_data
);

    t_window   r_win, n_win;
    logic [2:0] r_fill, n_fill;
    logic      r_flush, n_flush;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    t_window   w_ins;
    t_window   w_dec_src;
    t_window   w_dropped;
    t_head     w_head;
    logic      w_out_free;
    logic      w_accept;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_flush && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        for (int i = 0; i < WindowBytes; i++) begin
            if (3'(i) < r_fill) begin
                w_ins[i] = r_win[i];
            end else if (3'(i) == r_fill) begin
                w_ins[i] = i_in_data.text_byte;
            end else begin
                w_ins[i] = 8'd0;
            end
        end
    end

    assign w_dec_src = r_flush ? r_win : w_ins;

    u8d_head_decode u_head_decode (
        .i_window (w_dec_src),
        .o_head   (w_head)
    );

    assign w_dropped = t_window'(w_dec_src >> {w_head.bytes_used, 3'b000});

    always_comb begin
        n_win       = r_win;
        n_fill      = r_fill;
        n_flush     = r_flush;
        n_out_valid = w_out_free ? 1'b0 : r_out_valid;
        n_out       = r_out;
        if (r_flush) begin
            if (w_out_free) begin
                n_out_valid         = 1'b1;
                n_out.code_point    = w_head.code_point;
                n_out.error_mask    = w_head.error_mask;
                n_out.bytes_used    = w_head.bytes_used;
                n_out.last_char     = (w_head.bytes_used >= r_fill);
                if (w_head.bytes_used >= r_fill) begin
                    n_flush = 1'b0;
                    n_win   = '0;
                    n_fill  = 3'd0;
                end else begin
                    n_win  = w_dropped;
                    n_fill = r_fill - w_head.bytes_used;
                end
            end
        end else if (w_accept) begin
            if (i_in_data.end_of_text) begin
                n_win   = w_ins;
                n_fill  = r_fill + 3'd1;
                n_flush = 1'b1;
            end else if (r_fill == 3'd3) begin
                n_out_valid      = 1'b1;
                n_out.code_point = w_head.code_point;
                n_out.error_mask = w_head.error_mask;
                n_out.bytes_used = w_head.bytes_used;
                n_out.last_char  = 1'b0;
                n_win            = w_dropped;
                n_fill           = 3'd4 - w_head.bytes_used;
            end else begin
                n_win  = w_ins;
                n_fill = r_fill + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_fill      <= 3'd0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_win       <= n_win;
            r_fill      <= n_fill;
            r_flush     <= n_flush;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for utf8_stream_decoder: random bursts of UTF-8 text bytes in,
// decoded characters checked field by field against an in-bench window predictor.
// Depends on u8d_pkg and the decoder RTL.
`default_nettype none

module testbench;
    import u8d_pkg::*;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned HoldOffCycles = 400;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} t_rx_mode;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    t_in_item   text_bytes_q[$];
    t_out_item  decoded_q[$];
    logic [7:0] text_buf[$];

    t_window    lookahead = '0;
    logic [2:0] held = '0;

    int unsigned n_errors = 0;
    int unsigned n_bytes = 0;
    int unsigned n_total = 0;
    int unsigned n_texts = 0;
    int unsigned n_chars = 0;
    int unsigned n_flagged = 0;
    int unsigned n_in_stalls = 0;
    int unsigned cycles = 0;

    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    logic        holdoff_done = 1'b0;
    logic [5:0]  rx_tick = '0;
    t_rx_mode    rx_mode = RX_OPEN;

    utf8_stream_decoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 clk = ~clk;

    function automatic t_out_item decode_front(t_window w);
        logic [2:0]  n;
        logic [31:0] lead;
        logic [31:0] floor_val;
        logic [31:0] cp;
        logic [31:0] err;
        int unsigned cp_sh;
        int unsigned err_sh;
        t_out_item   r;
        if (!w[0][7]) n = 3'd1;
        else if (w[0][7:5] == 3'b110) n = 3'd2;
        else if (w[0][7:4] == 4'b1110) n = 3'd3;
        else if (w[0][7:3] == 5'b11110) n = 3'd4;
        else n = 3'd0;
        case (n)
            3'd1: begin lead = 32'h7f; floor_val = 0; cp_sh = 18; err_sh = 6; end
            3'd2: begin lead = 32'h1f; floor_val = 128; cp_sh = 12; err_sh = 4; end
            3'd3: begin lead = 32'h0f; floor_val = 2048; cp_sh = 6; err_sh = 2; end
            3'd4: begin lead = 32'h07; floor_val = 65536; cp_sh = 0; err_sh = 0; end
            default: begin lead = 32'h0; floor_val = 4194304; cp_sh = 0; err_sh = 0; end
        endcase
        cp = ((32'(w[0]) & lead) << 18) | (32'(w[1][5:0]) << 12)
           | (32'(w[2][5:0]) << 6) | 32'(w[3][5:0]);
        cp = cp >> cp_sh;
        err = '0;
        err[6] = cp < floor_val;
        err[7] = (cp >> 11) == 32'h1b;
        err[8] = cp > 32'h10FFFF;
        err[5:4] = w[1][7:6];
        err[3:2] = w[2][7:6];
        err[1:0] = w[3][7:6];
        err = (err ^ 32'h2a) >> err_sh;
        r.code_point = cp[20:0];
        r.error_mask = err[8:0];
        r.bytes_used = (n == 3'd0) ? 3'd1 : n;
        r.last_char = 1'b0;
        return r;
    endfunction

    task automatic drop_front(input logic [2:0] adv);
        for (int i = 0; i < 4; i++) begin
            lookahead[i] = (i + adv < 4) ? lookahead[i + adv] : 8'h00;
        end
        held = (held > adv) ? held - adv : 3'd0;
    endtask

    task automatic take_byte(input t_in_item it);
        t_out_item r;
        int        n;
        n = 0;
        if (held > 3'd3) held = 3'd3;
        lookahead[held] = it.text_byte;
        held = held + 3'd1;
        for (int i = 0; i < 4; i++) begin
            if (i >= held) lookahead[i] = 8'h00;
        end
        if (!it.end_of_text) begin
            if (held == 3'd4) begin
                r = decode_front(lookahead);
                decoded_q = {decoded_q, r};
                drop_front(r.bytes_used);
            end
        end else begin
            while (held > 0 && n < 4) begin
                r = decode_front(lookahead);
                r.last_char = r.bytes_used >= held;
                decoded_q = {decoded_q, r};
                drop_front(r.bytes_used);
                n++;
            end
            held = '0;
            lookahead = '0;
        end
    endtask

    task automatic report(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report($sformatf("char %0d %s: got 0x%0h, want 0x%0h", n_chars, name, got, want));
        end
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!in_valid || o_in_ready) begin
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (text_bytes_q.size() != 0) begin
                in_valid <= 1'b1;
                in_data <= text_bytes_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 6'd1;
            if (hold_left != 0) begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!holdoff_done && n_bytes >= 150) begin
                holdoff_done <= 1'b1;
                hold_left <= HoldOffCycles;
                out_ready <= 1'b0;
            end else begin
                if (rx_tick == 0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
                case (rx_mode)
                    RX_OPEN: out_ready <= 1'b1;
                    RX_COIN: out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (rx_tick[2:0] != 3'd5) && (rx_tick[2:0] != 3'd6);
                endcase
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n) begin
            if (in_valid && o_in_ready) begin
                take_byte(in_data);
                n_bytes++;
                if (in_data.end_of_text) n_texts++;
            end
            if (in_valid && !o_in_ready) n_in_stalls++;
            if (o_out_valid && out_ready) begin
                if (decoded_q.size() == 0) begin
                    report($sformatf("unexpected character 0x%0h", o_out_data.code_point));
                end else begin
                    want = decoded_q.pop_front();
                    check_field("code_point", 32'(o_out_data.code_point),
                                32'(want.code_point));
                    check_field("error_mask", 32'(o_out_data.error_mask),
                                32'(want.error_mask));
                    check_field("bytes_used", 32'(o_out_data.bytes_used),
                                32'(want.bytes_used));
                    check_field("last_char", 32'(o_out_data.last_char),
                                32'(want.last_char));
                    if (want.error_mask != 0) n_flagged++;
                end
                n_chars++;
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycles, decoded_q.size());
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] b);
        text_buf = {text_buf, b};
    endtask

    task automatic close_text();
        t_in_item it;
        for (int i = 0; i < text_buf.size(); i++) begin
            it.text_byte = text_buf[i];
            it.end_of_text = (i == text_buf.size() - 1);
            text_bytes_q = {text_bytes_q, it};
        end
        text_buf.delete();
    endtask

    task automatic put_len(input logic [20:0] cp, input int n);
        case (n)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic put_random_char();
        int          pick;
        int          n;
        logic [20:0] cp;
        pick = $urandom_range(0, 99);
        n = $urandom_range(2, 4);
        if (pick < 30) begin
            put_len(21'($urandom_range(0, 32'h7F)), 1);
        end else if (pick < 50) begin
            put_len(21'($urandom_range(32'h80, 32'h7FF)), 2);
        end else if (pick < 65) begin
            cp = 21'($urandom_range(32'h800, 32'hFFFF));
            if (cp[15:11] == 5'h1b) cp = cp ^ 21'h4000;
            put_len(cp, 3);
        end else if (pick < 78) begin
            put_len(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
        end else if (pick < 82) begin
            put_len(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
        end else if (pick < 85) begin
            put_len(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
        end else if (pick < 88) begin
            put_len(21'($urandom_range(0, 32'h7F)), n);
        end else if (pick < 92) begin
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 95) begin
            add_byte(8'($urandom_range(8'hF8, 8'hFF)));
        end else if (pick < 98) begin
            put_len(21'($urandom_range(32'h80, 32'h10FFFF)), n);
            repeat ($urandom_range(1, n - 1)) void'(text_buf.pop_back());
        end else begin
            put_len(21'($urandom_range(32'h80, 32'h10FFFF)), n);
            text_buf[text_buf.size() - 1] = 8'($urandom_range(0, 255));
        end
    endtask

    initial begin
        int n_set;
        // single-byte text, full valid range, then each error class and a cut-off tail
        text_buf = '{8'h00};
        close_text();
        text_buf = '{8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        close_text();
        text_buf = '{8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80};
        close_text();
        text_buf = '{8'h80, 8'hFF, 8'hF0, 8'h9F};
        close_text();
        text_buf = '{8'hE2, 8'h28, 8'hA1};
        close_text();
        while (text_bytes_q.size() < 430) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)));
            end else begin
                n_set = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
                repeat (n_set) put_random_char();
            end
            close_text();
        end
        n_total = text_bytes_q.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (n_bytes < n_total || decoded_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d texts, %0d bytes in, %0d characters out (%0d malformed)",
                 n_texts, n_bytes, n_chars, n_flagged);
        $display("input held off for %0d cycles, incl. one %0d-cycle output stall",
                 n_in_stalls, HoldOffCycles);
        if (n_errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/u8d_pkg.sv
src/u8d_head_decode.sv
src/utf8_stream_decoder.sv
tb/testbench.sv
